// ===== sv/rast_pkg.sv =====
package rast_pkg;

  // Field widths of the request and response channels
  localparam int unsigned VAL_W = 31;
  localparam int unsigned POS_W = 11;

  // Default tree size in leaves
  localparam int unsigned LEAVES_DEF = 1024;

  // Request action codes
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // One tree node: minimum value below it and the position holding it
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } node_t;

  typedef enum logic [3:0] {
    ST_INIT_LEAF,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_RD,
    ST_QRY_CMB,
    ST_QRY_OUT
  } state_e;

  // Strict order on nodes: value first, lower position wins ties
  function automatic logic pair_less(node_t a, node_t b);
    logic lt;
    if (a.value != b.value) begin
      lt = (a.value < b.value);
    end else begin
      lt = (a.pos < b.pos);
    end
    return lt;
  endfunction

endpackage

// ===== sv/rast_if.sv =====
// Request channel: one update or query per request
interface rast_req_if;
  import rast_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] last_pos;
  logic [VAL_W-1:0] new_value;

  modport source (output valid, action, first_pos, last_pos, new_value, input ready);
  modport sink   (input valid, action, first_pos, last_pos, new_value, output ready);
endinterface

// Response channel: one per query
interface rast_rsp_if;
  import rast_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] min_value;
  logic [POS_W-1:0] min_pos;

  modport source (output valid, found, min_value, min_pos, input ready);
  modport sink   (input valid, found, min_value, min_pos, output ready);
endinterface

// ===== sv/range_argmin_segment_tree_core.sv =====
// Update: the leaf is written as the request is taken, then each ancestor level takes a
//   read-compare-write step (ST_UPD_RD, ST_UPD_WR) through the node memory up to the root.
// Query: a read step and a fold step per visited tree level, up to log2(LEAVES)+1 levels,
//   one node pair read per level; an empty range goes straight to the response state.
//   One request is in work at a time.
// Reset: asynchronous, active low. A build pass that writes every leaf and then each inner
//   node, from the last one down to the root, fills the node memory while ready stays low.
module range_argmin_segment_tree_core #(
  parameter int unsigned LEAVES = rast_pkg::LEAVES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rast_req_if.sink   req_i,
  rast_rsp_if.source rsp_o
);
  import rast_pkg::*;

  localparam int unsigned NodeW = $clog2(2 * LEAVES);
  localparam int unsigned IdxW  = NodeW + 1;
  localparam int unsigned CmpW  = (IdxW > POS_W) ? IdxW : POS_W;

  localparam logic [CmpW-1:0]  LeavesC = CmpW'(LEAVES);
  localparam logic [NodeW-1:0] LeavesN = NodeW'(LEAVES);
  localparam logic [NodeW-1:0] LastInt = NodeW'(LEAVES - 1);

  state_e state_q, state_d;

  logic [NodeW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]  l_q, l_d;
  logic [IdxW-1:0]  r_q, r_d;
  logic             have_q, have_d;
  node_t            best_q, best_d;

  logic             rsp_valid_q, rsp_valid_d;
  logic             rsp_found_q, rsp_found_d;
  logic [VAL_W-1:0] rsp_value_q, rsp_value_d;
  logic [POS_W-1:0] rsp_pos_q, rsp_pos_d;

  logic             wr_en;
  logic [NodeW-1:0] wr_addr;
  node_t            wr_data;
  logic [NodeW-1:0] rd_a_addr;
  logic [NodeW-1:0] rd_b_addr;
  node_t            rd_a;
  node_t            rd_b;

  rast_node_ram #(
    .LEAVES(LEAVES)
  ) u_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_a_addr_i(rd_a_addr),
    .rd_b_addr_i(rd_b_addr),
    .rd_a_o     (rd_a),
    .rd_b_o     (rd_b)
  );

  // Decode the request: bounds, clamping and leaf indices
  logic            req_fire;
  logic [CmpW-1:0] first_ext;
  logic [CmpW-1:0] last_ext;
  logic [CmpW-1:0] first_clamp;
  logic [CmpW-1:0] last_clamp;
  logic            upd_ok;
  logic            qry_empty;
  logic [CmpW-1:0] leaf_first;
  logic [CmpW-1:0] leaf_end;

  assign req_fire    = req_i.valid && req_i.ready;
  assign first_ext   = CmpW'(req_i.first_pos);
  assign last_ext    = CmpW'(req_i.last_pos);
  assign upd_ok      = (first_ext != '0) && (first_ext <= LeavesC);
  assign first_clamp = (first_ext == '0) ? CmpW'(1) : first_ext;
  assign last_clamp  = (last_ext > LeavesC) ? LeavesC : last_ext;
  assign qry_empty   = (first_clamp > last_clamp);
  assign leaf_first  = LeavesC + first_clamp - CmpW'(1);
  assign leaf_end    = LeavesC + last_clamp;

  // Smaller of the two children read back
  node_t pull_min;
  assign pull_min = pair_less(rd_b, rd_a) ? rd_b : rd_a;

  // Fold the left and right boundary nodes into the running minimum
  node_t           fold_best;
  logic            fold_have;
  logic [IdxW-1:0] l_next;
  logic [IdxW-1:0] r_next;

  always_comb begin
    fold_best = best_q;
    fold_have = have_q;
    if (l_q[0] && (!fold_have || pair_less(rd_a, fold_best))) begin
      fold_best = rd_a;
      fold_have = 1'b1;
    end
    if (r_q[0] && (!fold_have || pair_less(rd_b, fold_best))) begin
      fold_best = rd_b;
      fold_have = 1'b1;
    end
  end

  assign l_next = (l_q + IdxW'(l_q[0])) >> 1;
  assign r_next = r_q >> 1;

  logic rsp_free;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT_LEAF: if (cnt_q == LastInt) state_d = ST_INIT_RD;
      ST_INIT_RD:   state_d = ST_INIT_WR;
      ST_INIT_WR:   state_d = (cnt_q == NodeW'(1)) ? ST_IDLE : ST_INIT_RD;
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.action == ACT_QUERY) begin
            state_d = qry_empty ? ST_QRY_OUT : ST_QRY_RD;
          end else if (upd_ok) begin
            state_d = ST_UPD_RD;
          end
        end
      end
      ST_UPD_RD:  state_d = ST_UPD_WR;
      ST_UPD_WR:  state_d = (cnt_q == NodeW'(1)) ? ST_IDLE : ST_UPD_RD;
      ST_QRY_RD:  state_d = ST_QRY_CMB;
      ST_QRY_CMB: state_d = (l_next < r_next) ? ST_QRY_RD : ST_QRY_OUT;
      ST_QRY_OUT: if (rsp_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Memory control and handshake outputs
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = cnt_q;
    wr_data   = pull_min;
    rd_a_addr = {cnt_q[NodeW-2:0], 1'b0};
    rd_b_addr = {cnt_q[NodeW-2:0], 1'b1};
    unique case (state_q)
      ST_INIT_LEAF: begin
        wr_en         = 1'b1;
        wr_addr       = LeavesN + cnt_q;
        wr_data.value = '0;
        wr_data.pos   = POS_W'(CmpW'(cnt_q) + CmpW'(1));
      end
      ST_INIT_WR, ST_UPD_WR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        wr_en         = req_fire && (req_i.action == ACT_UPDATE) && upd_ok;
        wr_addr       = NodeW'(leaf_first);
        wr_data.value = req_i.new_value;
        wr_data.pos   = req_i.first_pos;
      end
      ST_QRY_RD: begin
        rd_a_addr = l_q[NodeW-1:0];
        rd_b_addr = NodeW'(r_q - IdxW'(1));
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  // Datapath registers
  always_comb begin
    cnt_d       = cnt_q;
    l_d         = l_q;
    r_d         = r_q;
    have_d      = have_q;
    best_d      = best_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_found_d = rsp_found_q;
    rsp_value_d = rsp_value_q;
    rsp_pos_d   = rsp_pos_q;
    case (state_q)
      ST_INIT_LEAF: cnt_d = (cnt_q == LastInt) ? LastInt : cnt_q + NodeW'(1);
      ST_INIT_WR:   cnt_d = cnt_q - NodeW'(1);
      ST_IDLE: begin
        if (req_fire) begin
          cnt_d  = NodeW'(leaf_first >> 1);
          l_d    = IdxW'(leaf_first);
          r_d    = IdxW'(leaf_end);
          have_d = 1'b0;
        end
      end
      ST_UPD_WR:  cnt_d = cnt_q >> 1;
      ST_QRY_CMB: begin
        l_d    = l_next;
        r_d    = r_next;
        have_d = fold_have;
        best_d = fold_best;
      end
      ST_QRY_OUT: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_found_d = have_q;
          rsp_value_d = have_q ? best_q.value : '0;
          rsp_pos_d   = have_q ? best_q.pos : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT_LEAF;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    l_q         <= l_d;
    r_q         <= r_d;
    have_q      <= have_d;
    best_q      <= best_d;
    rsp_found_q <= rsp_found_d;
    rsp_value_q <= rsp_value_d;
    rsp_pos_q   <= rsp_pos_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.found     = rsp_found_q;
  assign rsp_o.min_value = rsp_value_q;
  assign rsp_o.min_pos   = rsp_pos_q;

`ifndef NO_ASSERTIONS
  // A query read step always has a non-empty span left
  a_qry_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY_RD) |-> (l_q < r_q))
    else $error("query read with empty span");

  // Queries never write the node memory
  a_qry_no_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY_RD || state_q == ST_QRY_CMB || state_q == ST_QRY_OUT) |-> !wr_en)
    else $error("node write during query");

  // The ancestor walk never reaches the unused node
  a_upd_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_RD || state_q == ST_UPD_WR) |-> (cnt_q != '0))
    else $error("update walk on node zero");

  // A response appears only out of the response state
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_QRY_OUT))
    else $error("response without a query");
`endif

endmodule

// ===== sv/rast_node_ram.sv =====
module rast_node_ram #(
  parameter int unsigned LEAVES = rast_pkg::LEAVES_DEF
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(2*LEAVES)-1:0]     wr_addr_i,
  input  rast_pkg::node_t                 wr_data_i,
  input  logic [$clog2(2*LEAVES)-1:0]     rd_a_addr_i,
  input  logic [$clog2(2*LEAVES)-1:0]     rd_b_addr_i,
  output rast_pkg::node_t                 rd_a_o,
  output rast_pkg::node_t                 rd_b_o
);
  import rast_pkg::*;

  localparam int unsigned Depth = 2 * LEAVES;

  node_t mem_q [Depth];
  node_t rd_a_q;
  node_t rd_b_q;

  // Write one node per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[rd_a_addr_i];
    rd_b_q <= mem_q[rd_b_addr_i];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ===== bench/tb_rast_checker.sv =====
// Watches both channels, keeps a private copy of the tree and checks every response
module tb_rast_checker #(
  parameter int unsigned LEAVES = rast_pkg::LEAVES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rast_req_if         req_mon_i,
  rast_rsp_if         rsp_mon_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned updates_o,
  output int unsigned dropped_o,
  output int unsigned queries_o,
  output int unsigned empties_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import rast_pkg::*;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] min_value;
    logic [POS_W-1:0] min_pos;
  } answer_t;

  // Shadow tree: node 1 is the root, leaf for position p is LEAVES + p - 1
  node_t       tree_nodes [2*LEAVES];
  answer_t     answers_due [$];

  int unsigned mismatches   = 0;
  int unsigned n_updates    = 0;
  int unsigned n_dropped    = 0;
  int unsigned n_queries    = 0;
  int unsigned n_empty      = 0;

  // Strict order: smaller value first, lower position on equal values
  function automatic logic node_below(node_t a, node_t b);
    if (a.value != b.value) begin
      return a.value < b.value;
    end
    return a.pos < b.pos;
  endfunction

  function automatic node_t pair_min(int unsigned k);
    node_t lhs;
    node_t rhs;
    lhs = tree_nodes[2*k];
    rhs = tree_nodes[2*k+1];
    return node_below(rhs, lhs) ? rhs : lhs;
  endfunction

  // Write one leaf and recompute its ancestors; drop positions outside the tree
  function automatic logic write_leaf(logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int unsigned k;
    if (pos < 1 || pos > LEAVES) begin
      return 1'b0;
    end
    k = LEAVES + pos - 1;
    tree_nodes[k].value = val;
    for (k = k >> 1; k > 0; k = k >> 1) begin
      tree_nodes[k] = pair_min(k);
    end
    return 1'b1;
  endfunction

  // Minimum over the clamped inclusive range, walking up from both ends
  function automatic answer_t range_min(logic [POS_W-1:0] lo_in, logic [POS_W-1:0] hi_in);
    int unsigned lo;
    int unsigned hi;
    int unsigned l;
    int unsigned r;
    logic        have;
    node_t       best;
    answer_t     ans;
    lo   = lo_in;
    hi   = hi_in;
    ans  = '0;
    have = 1'b0;
    best = '0;
    if (lo < 1) lo = 1;
    if (hi > LEAVES) hi = LEAVES;
    if (lo > hi) begin
      return ans;
    end
    l = LEAVES + lo - 1;
    r = LEAVES + hi;
    while (l < r) begin
      if ((l & 1) != 0) begin
        if (!have || node_below(tree_nodes[l], best)) begin
          best = tree_nodes[l];
          have = 1'b1;
        end
        l++;
      end
      if ((r & 1) != 0) begin
        r--;
        if (!have || node_below(tree_nodes[r], best)) begin
          best = tree_nodes[r];
          have = 1'b1;
        end
      end
      l = l >> 1;
      r = r >> 1;
    end
    ans.found     = have;
    ans.min_value = best.value;
    ans.min_pos   = best.pos;
    return ans;
  endfunction

  // Build the post-reset tree: zero values, each leaf holding its own position
  initial begin
    tree_nodes[0] = '0;
    for (int unsigned i = 0; i < LEAVES; i++) begin
      tree_nodes[LEAVES+i].value = '0;
      tree_nodes[LEAVES+i].pos   = POS_W'(i + 1);
    end
    for (int unsigned i = LEAVES - 1; i > 0; i--) begin
      tree_nodes[i] = pair_min(i);
    end
  end

  // Retire the response first, then predict the request of the same edge
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (answers_due.size() == 0) begin
          $error("response with no query outstanding: found %0d value %0d pos %0d",
                 rsp_mon_i.found, rsp_mon_i.min_value, rsp_mon_i.min_pos);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_mon_i.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_mon_i.found);
            mismatches++;
          end
          if (rsp_mon_i.min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, rsp_mon_i.min_value);
            mismatches++;
          end
          if (rsp_mon_i.min_pos !== want.min_pos) begin
            $error("min_pos: expected %0d, got %0d", want.min_pos, rsp_mon_i.min_pos);
            mismatches++;
          end
        end
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        if (req_mon_i.action == ACT_UPDATE) begin
          n_updates++;
          if (!write_leaf(req_mon_i.first_pos, req_mon_i.new_value)) begin
            n_dropped++;
          end
        end else begin
          want = range_min(req_mon_i.first_pos, req_mon_i.last_pos);
          n_queries++;
          if (!want.found) n_empty++;
          answers_due.push_back(want);
        end
      end
    end
    fail_cnt_o <= mismatches;
    pending_o  <= answers_due.size();
    updates_o  <= n_updates;
    dropped_o  <= n_dropped;
    queries_o  <= n_queries;
    empties_o  <= n_empty;
  end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the range argmin tree; checking lives in tb_rast_checker
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import rast_pkg::*;

  localparam int unsigned LEAVES     = LEAVES_DEF;
  localparam int unsigned RAND_ITEMS = 1850;
  localparam int unsigned QUIET_TAIL = 200;
  localparam int unsigned PAUSE_AT   = 700;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned LIMIT      = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        quiet;
  int unsigned cycle_cnt;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned updates_cnt;
  int unsigned dropped_cnt;
  int unsigned queries_cnt;
  int unsigned empties_cnt;

  rast_req_if req_ch ();
  rast_rsp_if rsp_ch ();

  range_argmin_segment_tree_core #(
    .LEAVES (LEAVES)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  tb_rast_checker #(
    .LEAVES (LEAVES)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon_i  (req_ch),
    .rsp_mon_i  (rsp_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt),
    .updates_o  (updates_cnt),
    .dropped_o  (dropped_cnt),
    .queries_o  (queries_cnt),
    .empties_o  (empties_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles and stop a hung run
  initial cycle_cnt = 0;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("timeout after %0d cycles, %0d responses still due", cycle_cnt, pending_cnt);
    $display("tb_top NOT OK");
    $finish;
  end

  // Response side: random stall bursts, always ready in the quiet tail
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    stall_left   = 0;
    run_left     = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        rsp_ch.ready <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        run_left = $urandom_range(0, 40);
      end
    end
  end

  // Pick a position, mostly inside the tree, now and then anywhere the field allows
  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 19) == 0) begin
      return POS_W'($urandom_range(0, 2047));
    end
    return POS_W'($urandom_range(1, LEAVES));
  endfunction

  // Present one request, with an optional idle burst ahead of it, and hold until taken
  task automatic send_request(input logic act, input logic [POS_W-1:0] lo,
                              input logic [POS_W-1:0] hi, input logic [VAL_W-1:0] val);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.first_pos <= lo;
    req_ch.last_pos  <= hi;
    req_ch.new_value <= val;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  initial begin
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [VAL_W-1:0] val;
    int unsigned      kind;
    int unsigned      shape;

    quiet            = 1'b0;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_UPDATE;
    req_ch.first_pos = '0;
    req_ch.last_pos  = '0;
    req_ch.new_value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, ties, dropped updates, clamped and empty ranges
    send_request(ACT_QUERY,  POS_W'(1),    POS_W'(LEAVES), '0);
    send_request(ACT_UPDATE, POS_W'(1),    '0,             {VAL_W{1'b1}});
    send_request(ACT_UPDATE, POS_W'(LEAVES), {POS_W{1'b1}}, '0);
    send_request(ACT_QUERY,  POS_W'(1),    POS_W'(LEAVES), '0);
    send_request(ACT_QUERY,  POS_W'(1),    POS_W'(1),      '0);
    send_request(ACT_QUERY,  POS_W'(LEAVES), POS_W'(LEAVES), {VAL_W{1'b1}});
    send_request(ACT_UPDATE, POS_W'(0),    '0,             VAL_W'(9));
    send_request(ACT_UPDATE, POS_W'(LEAVES + 1), '0,       VAL_W'(9));
    send_request(ACT_UPDATE, {POS_W{1'b1}}, '0,            VAL_W'(9));
    send_request(ACT_UPDATE, POS_W'(300),  '0,             VAL_W'(7));
    send_request(ACT_UPDATE, POS_W'(301),  '0,             VAL_W'(3));
    send_request(ACT_UPDATE, POS_W'(302),  '0,             VAL_W'(3));
    send_request(ACT_QUERY,  POS_W'(301),  POS_W'(302),    '0);
    send_request(ACT_QUERY,  POS_W'(300),  POS_W'(302),    '0);
    send_request(ACT_QUERY,  POS_W'(300),  POS_W'(300),    '0);
    send_request(ACT_UPDATE, POS_W'(512),  '0,             VAL_W'(32'h5555_5555));
    send_request(ACT_UPDATE, POS_W'(513),  '0,             VAL_W'(32'h2AAA_AAAA));
    send_request(ACT_QUERY,  POS_W'(512),  POS_W'(513),    '0);
    send_request(ACT_QUERY,  POS_W'(0),    {POS_W{1'b1}},  '0);
    send_request(ACT_QUERY,  POS_W'(5),    POS_W'(3),      '0);
    send_request(ACT_QUERY,  POS_W'(LEAVES + 1), {POS_W{1'b1}}, '0);
    send_request(ACT_QUERY,  POS_W'(0),    POS_W'(0),      '0);

    // Random: mixed updates and queries with range shapes from single points to full
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= RAND_ITEMS - QUIET_TAIL);
      if (n == PAUSE_AT) begin
        // Hold off until every outstanding query has answered
        req_ch.valid <= 1'b0;
        do @(posedge clk_i); while (pending_cnt != 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        case ($urandom_range(0, 3))
          0:       val = VAL_W'($urandom_range(0, 7));
          1:       val = VAL_W'($urandom());
          2:       val = {VAL_W{1'b1}};
          default: val = VAL_W'($urandom_range(0, 1000));
        endcase
        send_request(ACT_UPDATE, pick_pos(), POS_W'($urandom()), val);
      end else begin
        shape = $urandom_range(0, 9);
        if (shape < 4) begin
          lo = pick_pos();
          hi = POS_W'(int'(lo) + $urandom_range(0, 16));
        end else if (shape < 7) begin
          lo = pick_pos();
          hi = pick_pos();
        end else if (shape == 7) begin
          lo = POS_W'(1);
          hi = POS_W'(LEAVES);
        end else if (shape == 8) begin
          hi = POS_W'($urandom_range(1, LEAVES - 1));
          lo = POS_W'(int'(hi) + $urandom_range(1, LEAVES - hi));
        end else begin
          lo = POS_W'($urandom_range(0, 2047));
          hi = POS_W'($urandom_range(0, 2047));
        end
        send_request(ACT_QUERY, lo, hi, VAL_W'($urandom()));
      end
    end

    // Drain: drop valid, wait for the last answers, then let the block settle
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Ran %0d updates (%0d outside the tree, dropped) and %0d range queries",
             updates_cnt, dropped_cnt, queries_cnt);
    $display("(%0d of them empty after clamping) in %0d cycles.", empties_cnt, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
